// ----- rtl/pdc_pkg.sv -----
// shared types, constants and the byte-wide crc-32 step for the packet deframer
// no dependencies; imported by every module of the block

package pdc_pkg;

	localparam int unsigned HEADER_BYTES = 32;
	localparam int unsigned CRC_END_BYTE = 28;
	localparam int unsigned COUNT_W      = 18;
	localparam int unsigned HDR_W        = 8 * HEADER_BYTES;
	localparam int unsigned ADDR_W       = 5;

	localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
	localparam logic [31:0]        CRC_INIT    = 32'hffff_ffff;
	localparam logic [31:0]        CRC_POLY    = 32'hedb8_8320;
	localparam logic [31:0]        PAYLOAD_CAP = 32'd65536;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_MAGIC   = 3'd0;
	localparam logic [2:0] REG_VERSION = 3'd1;
	localparam logic [2:0] REG_TYPE_A  = 3'd2;
	localparam logic [2:0] REG_TYPE_B  = 3'd3;
	localparam logic [2:0] REG_TYPE_C  = 3'd4;
	localparam logic [2:0] REG_MAX_PAY = 3'd5;

	typedef enum logic [3:0] {
		ST_OK        = 4'd0,
		ST_SHORT_HDR = 4'd1,
		ST_MAGIC     = 4'd2,
		ST_VERSION   = 4'd3,
		ST_TYPE      = 4'd4,
		ST_TOO_LARGE = 4'd5,
		ST_SHORT_PAY = 4'd6,
		ST_LEN_MISM  = 4'd7,
		ST_CRC       = 4'd8
	} status_t;

	typedef struct packed {
		logic [31:0] magic;
		logic [15:0] version;
		logic [15:0] type_a;
		logic [15:0] type_b;
		logic [15:0] type_c;
		logic [16:0] max_pay;
	} cfg_t;

	// packet state with the current byte already folded in
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [HDR_W-1:0]   header;
		logic [31:0]        crc;
	} trk_view_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] msg_type;
		logic [63:0] seq_num;
		logic [63:0] source_timestamp;
		logic [31:0] pay_len;
	} result_t;

	function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in, input logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = {1'b0, c[31:1]} ^ (CRC_POLY & {32{c[0]}});
		end
		return c;
	endfunction

endpackage

// ----- rtl/pdc_regs.sv -----
// apb configuration registers of the packet deframer
// depends on pdc_pkg

module pdc_regs
	import pdc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t        cfg_q;
	logic        wr_en;
	logic [2:0]  reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic   <= 32'd0;
			cfg_q.version <= 16'd1;
			cfg_q.type_a  <= 16'd1;
			cfg_q.type_b  <= 16'd2;
			cfg_q.type_c  <= 16'd3;
			cfg_q.max_pay <= 17'd65536;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MAGIC:   cfg_q.magic   <= pwdata;
				REG_VERSION: cfg_q.version <= pwdata[15:0];
				REG_TYPE_A:  cfg_q.type_a  <= pwdata[15:0];
				REG_TYPE_B:  cfg_q.type_b  <= pwdata[15:0];
				REG_TYPE_C:  cfg_q.type_c  <= pwdata[15:0];
				REG_MAX_PAY: cfg_q.max_pay <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MAGIC:   prdata = cfg_q.magic;
			REG_VERSION: prdata = {16'd0, cfg_q.version};
			REG_TYPE_A:  prdata = {16'd0, cfg_q.type_a};
			REG_TYPE_B:  prdata = {16'd0, cfg_q.type_b};
			REG_TYPE_C:  prdata = {16'd0, cfg_q.type_c};
			REG_MAX_PAY: prdata = {15'd0, cfg_q.max_pay};
			default:     prdata = 32'd0;
		endcase
	end

endmodule

// ----- rtl/pdc_track.sv -----
// per-packet state: saturating byte count, header shift register, running crc
// depends on pdc_pkg

module pdc_track
	import pdc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output trk_view_t  view
);

	logic [COUNT_W-1:0] count_q;
	logic [HDR_W-1:0]   header_q;
	logic [31:0]        crc_q;
	logic               in_header;
	logic               in_crc_span;

	assign in_header   = count_q < COUNT_W'(HEADER_BYTES);
	assign in_crc_span = (count_q < COUNT_W'(CRC_END_BYTE)) || !in_header;

	always_comb begin
		view.count  = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_W'(1);
		view.header = in_header ? {header_q[HDR_W-9:0], data_byte} : header_q;
		view.crc    = in_crc_span ? crc32_byte(crc_q, data_byte) : crc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			header_q <= '0;
			crc_q    <= CRC_INIT;
		end else if (advance) begin
			if (last_byte) begin
				count_q  <= '0;
				header_q <= '0;
				crc_q    <= CRC_INIT;
			end else begin
				count_q  <= view.count;
				header_q <= view.header;
				crc_q    <= view.crc;
			end
		end
	end

endmodule

// ----- rtl/pdc_check.sv -----
// header field split and prioritized status checks for a finished packet
// depends on pdc_pkg

module pdc_check
	import pdc_pkg::*;
(
	input  trk_view_t view,
	input  cfg_t      cfg,
	output result_t   res
);

	logic [31:0] magic;
	logic [15:0] version;
	logic [15:0] mtype;
	logic [31:0] plen;
	logic [31:0] hcrc;
	logic [31:0] limit;
	logic [32:0] expected;
	logic [32:0] total;
	logic        type_ok;

	assign magic    = view.header[255:224];
	assign version  = view.header[223:208];
	assign mtype    = view.header[207:192];
	assign plen     = view.header[63:32];
	assign hcrc     = view.header[31:0];
	assign limit    = ({15'd0, cfg.max_pay} > PAYLOAD_CAP) ? PAYLOAD_CAP
	                                                       : {15'd0, cfg.max_pay};
	assign expected = 33'(HEADER_BYTES) + {1'b0, plen};
	assign total    = {{(33-COUNT_W){1'b0}}, view.count};
	assign type_ok  = (mtype == cfg.type_a) || (mtype == cfg.type_b) || (mtype == cfg.type_c);

	always_comb begin
		res.msg_type         = mtype;
		res.seq_num          = view.header[191:128];
		res.source_timestamp = view.header[127:64];
		res.pay_len          = plen;
		if (view.count < COUNT_W'(HEADER_BYTES)) begin
			res.status           = ST_SHORT_HDR;
			res.msg_type         = '0;
			res.seq_num          = '0;
			res.source_timestamp = '0;
			res.pay_len          = '0;
		end else if (magic != cfg.magic) begin
			res.status = ST_MAGIC;
		end else if (version != cfg.version) begin
			res.status = ST_VERSION;
		end else if (!type_ok) begin
			res.status = ST_TYPE;
		end else if (plen > limit) begin
			res.status = ST_TOO_LARGE;
		end else if (total < expected) begin
			res.status = ST_SHORT_PAY;
		end else if (total != expected) begin
			res.status = ST_LEN_MISM;
		end else if ((view.crc ^ CRC_INIT) != hcrc) begin
			res.status = ST_CRC;
		end else begin
			res.status = ST_OK;
		end
	end

endmodule

// ----- rtl/packet_deframer_crc32_check.sv -----
// top level of the fixed-header packet deframer with crc-32 check
// a result passes the input register and then the result register after its last byte is accepted
// one byte per cycle unless out_stall holds a last byte; crc step and checks sit between the registers
// reset (arst_n low, asynchronous): pipeline empty, packet state cleared, registers at defaults
// depends on pdc_pkg, pdc_regs, pdc_track, pdc_check

module packet_deframer_crc32_check
	import pdc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// byte input transactions
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	// result transactions, one per packet
	output logic              out_valid,
	input  logic              out_stall,
	output logic [3:0]        status,
	output logic [15:0]       msg_type,
	output logic [63:0]       seq_num,
	output logic [63:0]       source_timestamp,
	output logic [31:0]       pay_len,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t       cfg;
	trk_view_t  view;
	result_t    res;

	// input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// result register stage
	logic       valid_s2;
	result_t    res_s2;

	logic       in_take;
	logic       advance;
	logic       out_free;

	// the result register can take a new transaction when empty or being drained
	assign out_free = !valid_s2 || !out_stall;
	// a non-last byte never writes the result register, so it always moves on
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	pdc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// byte count, header capture and crc for the packet in flight
	pdc_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.view      (view)
	);

	// status is only used when the last byte advances
	pdc_check u_check (
		.view (view),
		.cfg  (cfg),
		.res  (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid        = valid_s2;
	assign status           = res_s2.status;
	assign msg_type         = res_s2.msg_type;
	assign seq_num          = res_s2.seq_num;
	assign source_timestamp = res_s2.source_timestamp;
	assign pay_len          = res_s2.pay_len;

`ifndef SYNTHESIS
	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> valid_s2)
		else $error("last byte advanced without a result");

	a_short_header_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.status == ST_SHORT_HDR |->
			res_s2.pay_len == 32'd0 && res_s2.msg_type == 16'd0)
		else $error("short header result carries header fields");
`endif

endmodule
